// ===== rtl/lpfd_pkg.sv =====
// Shared types and constants for the length-prefixed frame decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package lpfd_pkg;

   localparam int unsigned LENGTH_BYTES  = 4;
   localparam int unsigned HEADER_BYTES  = 14;
   localparam int unsigned PAYLOAD_PHASE = 14;
   localparam logic [31:0] MIN_BODY      = 32'd10;

   localparam logic [31:0] MAX_BODY_RESET = 32'd4194304;
   localparam logic [15:0] TAG_RESET      = 16'd0;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CSR_ADDR_W = 3;

   typedef enum logic [0:0] {
      REG_MAX_BODY_LENGTH = 1'b0,
      REG_STREAM_TAG      = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      OP_VERSION = 3'd0,
      OP_TYPE    = 3'd1,
      OP_ID      = 3'd2,
      OP_HEADER  = 3'd3,
      OP_PAYLOAD = 3'd4,
      OP_ERROR   = 3'd5
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [7:0]  data;
      logic [31:0] plen;
      logic        last;
   } cmd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== rtl/length_prefixed_frame_decoder.sv =====
// Throughput: one byte per cycle while req_ready is high, limited by the
// single-entry output register. Bytes reach it through the command queue.
// The four-entry command queue lets the front keep taking bytes while output stalls.
// Reset is synchronous, active high, and returns the parser, queue and registers
// to their initial values; after a length error, bytes are dropped until reset.
// Depends on lpfd_pkg, lpfd_front, lpfd_queue and lpfd_back.
`default_nettype none
module length_prefixed_frame_decoder
   import lpfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [7:0]            req_rx_byte,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [1:0]            rsp_kind,
   output      logic [7:0]            rsp_version,
   output      logic [7:0]            rsp_frame_type,
   output      logic [63:0]           rsp_frame_id,
   output      logic [31:0]           rsp_payload_length,
   output      logic [7:0]            rsp_payload_byte,
   output      logic                  rsp_last,
   output      logic [15:0]           rsp_tag,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready
);

   logic [31:0]      max_len_ff, max_len_in;
   logic [15:0]      tag_ff, tag_in;
   logic             csr_write;
   reg_index_type    csr_index;
   logic             push;
   cmd_entry_type    push_entry;
   cmd_entry_type    head;
   queue_status_type q_status;
   logic             pop;
   logic             err_latched;
   kind_type         kind;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[2]);

   always_comb begin
      max_len_in = max_len_ff;
      tag_in     = tag_ff;
      if (csr_write) begin
         case (csr_index)
            REG_MAX_BODY_LENGTH: max_len_in = pwdata;
            REG_STREAM_TAG:      tag_in     = pwdata[15:0];
            default:             max_len_in = max_len_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_MAX_BODY_LENGTH: prdata = max_len_ff;
         REG_STREAM_TAG:      prdata = {16'd0, tag_ff};
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_BODY_RESET;
         tag_ff     <= TAG_RESET;
      end else begin
         max_len_ff <= max_len_in;
         tag_ff     <= tag_in;
      end
   end

   lpfd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .max_body_length (max_len_ff),
      .queue_full      (q_status.full),
      .push            (push),
      .push_entry      (push_entry),
      .error_latched   (err_latched)
   );

   lpfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   lpfd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .queue_empty        (q_status.empty),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (kind),
      .rsp_version        (rsp_version),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_frame_id       (rsp_frame_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last           (rsp_last)
   );

   assign rsp_kind = kind;
   assign rsp_tag  = tag_ff;

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && kind == KIND_ERROR) |-> rsp_last)
      else $error("error result without last");

   a_header_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && kind == KIND_HEADER) |-> (rsp_last == (rsp_payload_length == 32'd0)))
      else $error("header last flag disagrees with payload length");

   a_no_push_after_error: assert property (@(posedge clock) disable iff (reset)
      err_latched |-> !push)
      else $error("command queued after length error");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("command queue overflow");

endmodule
`default_nettype wire

// ===== rtl/lpfd_front.sv =====
// Front end: accepts received bytes, tracks the header position and the
// payload count, checks the body length (queuing an error if it fails), and queues
// one command per byte after the length field. Depends on lpfd_pkg.
`default_nettype none
module lpfd_front
   import lpfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire logic [7:0]    req_rx_byte,
   input  wire logic [31:0]   max_body_length,
   input  wire logic          queue_full,
   output      logic          push,
   output      cmd_entry_type push_entry,
   output      logic          error_latched
);

   logic [3:0]  pos_ff, pos_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] left_ff, left_in;
   logic        err_ff, err_in;
   logic [31:0] len_shift;
   logic [31:0] plen;
   logic        accept;

   assign req_ready     = !queue_full;
   assign accept        = req_valid && req_ready;
   assign error_latched = err_ff;
   assign len_shift     = {len_ff[23:0], req_rx_byte};
   assign plen          = len_ff - MIN_BODY;

   always_comb begin
      pos_in          = pos_ff;
      len_in          = len_ff;
      left_in         = left_ff;
      err_in          = err_ff;
      push            = 1'b0;
      push_entry.op   = OP_PAYLOAD;
      push_entry.data = req_rx_byte;
      push_entry.plen = '0;
      push_entry.last = 1'b0;
      if (accept && !err_ff) begin
         if (pos_ff >= 4'(PAYLOAD_PHASE)) begin
            left_in         = left_ff - 32'd1;
            push            = 1'b1;
            push_entry.op   = OP_PAYLOAD;
            push_entry.last = (left_ff == 32'd1);
            if (left_ff == 32'd1) begin
               pos_in = '0;
            end
         end else if (pos_ff < 4'(LENGTH_BYTES)) begin
            len_in = len_shift;
            pos_in = pos_ff + 4'd1;
            if (pos_ff == 4'(LENGTH_BYTES - 1) &&
                (len_shift > max_body_length || len_shift < MIN_BODY)) begin
               err_in          = 1'b1;
               push            = 1'b1;
               push_entry.op   = OP_ERROR;
               push_entry.last = 1'b1;
            end
         end else if (pos_ff == 4'(LENGTH_BYTES)) begin
            pos_in        = pos_ff + 4'd1;
            push          = 1'b1;
            push_entry.op = OP_VERSION;
         end else if (pos_ff == 4'(LENGTH_BYTES + 1)) begin
            pos_in        = pos_ff + 4'd1;
            push          = 1'b1;
            push_entry.op = OP_TYPE;
         end else if (pos_ff == 4'(HEADER_BYTES - 1)) begin
            push            = 1'b1;
            push_entry.op   = OP_HEADER;
            push_entry.plen = plen;
            push_entry.last = (plen == 32'd0);
            left_in         = plen;
            len_in          = '0;
            pos_in          = (plen == 32'd0) ? 4'd0 : 4'(PAYLOAD_PHASE);
         end else begin
            pos_in        = pos_ff + 4'd1;
            push          = 1'b1;
            push_entry.op = OP_ID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         len_ff  <= '0;
         left_ff <= '0;
         err_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         left_ff <= left_in;
         err_ff  <= err_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/lpfd_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on lpfd_pkg.
`default_nettype none
module lpfd_queue
   import lpfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire cmd_entry_type push_entry,
   input  wire logic          pop,
   output cmd_entry_type      head,
   output queue_status_type   status
);

   cmd_entry_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign head   = mem_ff[rd_ff];
   assign status = '{full: (cnt_ff == QCNT_W'(QUEUE_DEPTH)), empty: (cnt_ff == '0)};

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/lpfd_back.sv =====
// Back end: collects the version, type and id bytes and builds the result
// records in the output register. Depends on lpfd_pkg.
`default_nettype none
module lpfd_back
   import lpfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_entry_type head,
   input  wire logic          queue_empty,
   output      logic          pop,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      kind_type      rsp_kind,
   output      logic [7:0]    rsp_version,
   output      logic [7:0]    rsp_frame_type,
   output      logic [63:0]   rsp_frame_id,
   output      logic [31:0]   rsp_payload_length,
   output      logic [7:0]    rsp_payload_byte,
   output      logic          rsp_last
);

   logic [7:0]  ver_ff, ver_in;
   logic [7:0]  typ_ff, typ_in;
   logic [63:0] id_ff, id_in;
   logic        valid_ff, valid_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  over_ff, over_in;
   logic [7:0]  otyp_ff, otyp_in;
   logic [63:0] oid_ff, oid_in;
   logic [31:0] oplen_ff, oplen_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic        olast_ff, olast_in;

   assign pop                = !queue_empty && (!valid_ff || rsp_ready);
   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_version        = over_ff;
   assign rsp_frame_type     = otyp_ff;
   assign rsp_frame_id       = oid_ff;
   assign rsp_payload_length = oplen_ff;
   assign rsp_payload_byte   = obyte_ff;
   assign rsp_last           = olast_ff;

   always_comb begin
      ver_in   = ver_ff;
      typ_in   = typ_ff;
      id_in    = id_ff;
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      over_in  = over_ff;
      otyp_in  = otyp_ff;
      oid_in   = oid_ff;
      oplen_in = oplen_ff;
      obyte_in = obyte_ff;
      olast_in = olast_ff;
      if (pop) begin
         case (head.op)
            OP_VERSION: begin
               ver_in = head.data;
            end
            OP_TYPE: begin
               typ_in = head.data;
            end
            OP_ID: begin
               id_in = {id_ff[55:0], head.data};
            end
            OP_HEADER: begin
               id_in    = '0;
               valid_in = 1'b1;
               kind_in  = KIND_HEADER;
               over_in  = ver_ff;
               otyp_in  = typ_ff;
               oid_in   = {id_ff[55:0], head.data};
               oplen_in = head.plen;
               obyte_in = '0;
               olast_in = head.last;
            end
            OP_PAYLOAD: begin
               valid_in = 1'b1;
               kind_in  = KIND_PAYLOAD;
               over_in  = '0;
               otyp_in  = '0;
               oid_in   = '0;
               oplen_in = '0;
               obyte_in = head.data;
               olast_in = head.last;
            end
            OP_ERROR: begin
               valid_in = 1'b1;
               kind_in  = KIND_ERROR;
               over_in  = '0;
               otyp_in  = '0;
               oid_in   = '0;
               oplen_in = '0;
               obyte_in = '0;
               olast_in = 1'b1;
            end
            default: begin
               valid_in = valid_ff && !rsp_ready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ver_ff   <= ver_in;
      typ_ff   <= typ_in;
      kind_ff  <= kind_in;
      over_ff  <= over_in;
      otyp_ff  <= otyp_in;
      oid_ff   <= oid_in;
      oplen_ff <= oplen_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         id_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         id_ff    <= id_in;
      end
   end

endmodule
`default_nettype wire
